// ----- design/sdip_pkg.sv -----
// Package: types, sizes and helpers shared by the set-dueling insertion policy block.
package sdip_pkg;

    localparam int SETS          = 64;
    localparam int WAYS          = 8;
    localparam int SELECTOR_BITS = 10;

    localparam int SET_W = $clog2(SETS);
    localparam int WAY_W = $clog2(WAYS);

    localparam int                     MASK_W  = 64;
    localparam int                     THR_W   = 17;
    localparam logic [THR_W-1:0]       THROTTLE_RESET = 17'd4096;
    localparam logic [SELECTOR_BITS-1:0] SEL_MAX =
        SELECTOR_BITS'((64'd1 << SELECTOR_BITS) - 64'd1);
    localparam logic [SELECTOR_BITS-1:0] SEL_THRESHOLD = SEL_MAX / 2;

    localparam int ORDER_W = WAYS * WAY_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIP_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LRU_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE = 2'd2;

    // Operation codes
    localparam logic OP_HIT  = 1'b0;
    localparam logic OP_MISS = 1'b1;

    typedef logic [WAYS-1:0][WAY_W-1:0] order_t;

    typedef struct packed {
        logic        op;
        logic [5:0]  set_index;
        logic [2:0]  hit_way;
        logic [15:0] rand_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0] victim_way;
        logic [2:0] old_position;
        logic       moved_to_mru;
        logic       chose_bimodal;
        logic [9:0] selector;
    } out_item_t;

    // Recency unit control and result
    typedef struct packed {
        logic             miss;
        logic             way_ok;
        logic [WAY_W-1:0] way;
        logic             fill_promote;
    } rec_ctl_t;

    typedef struct packed {
        logic             moved;
        logic [WAY_W-1:0] pos;
        logic [WAY_W-1:0] victim;
        order_t           order;
    } rec_res_t;

    function automatic order_t reset_order();
        order_t o;
        for (int p = 0; p < WAYS; p++)
        begin
            o[p] = WAY_W'(p);
        end
        return o;
    endfunction

endpackage

// ----- design/sdip_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sdip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/sdip_recency.sv -----
// Recency order update: locate the way, promote it to MRU, report victim and position.
module sdip_recency (
    input  sdip_pkg::order_t   order,
    input  sdip_pkg::rec_ctl_t ctl,
    output sdip_pkg::rec_res_t res
);

    logic                          found;
    logic [sdip_pkg::WAY_W-1:0]    hit_pos;
    logic [sdip_pkg::WAY_W-1:0]    pos;
    logic                          en;

    // Search from the LRU end down so the lowest matching position wins
    always_comb
    begin
        found   = 1'b0;
        hit_pos = '0;
        for (int q = sdip_pkg::WAYS - 1; q >= 0; q--)
        begin
            if (order[q] == ctl.way)
            begin
                found   = 1'b1;
                hit_pos = sdip_pkg::WAY_W'(q);
            end
        end
    end

    always_comb
    begin
        if (ctl.miss)
        begin
            pos = sdip_pkg::WAY_W'(sdip_pkg::WAYS - 1);
            en  = ctl.fill_promote;
        end
        else
        begin
            pos = hit_pos;
            en  = found && ctl.way_ok;
        end
    end

    always_comb
    begin
        res.moved  = en;
        res.pos    = (ctl.miss || en) ? pos : '0;
        res.victim = ctl.miss ? order[sdip_pkg::WAYS-1] : '0;
        res.order[0] = en ? order[pos] : order[0];
        for (int q = 1; q < sdip_pkg::WAYS; q++)
        begin
            if (en && (sdip_pkg::WAY_W'(q) <= pos))
            begin
                res.order[q] = order[q-1];
            end
            else
            begin
                res.order[q] = order[q];
            end
        end
    end

endmodule

// ----- design/set_dueling_insertion_policy_top.sv -----
// Top level: set-dueling insertion policy engine with per-set recency RAM.
// A taken command passes through the stage register, where its RAM read is
// resolved, and then the result register, which drives the result strobe (done);
// one command is taken every cycle.
// busy stays low: the engine never stalls and the receiver cannot stall.
// Reset clears the selector, the configuration registers (throttle to 4096)
// and the per-set written bits, so every set reads as way 0 MRU .. last way LRU.
module set_dueling_insertion_policy_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  sdip_pkg::in_item_t                  cmd,
    output logic                                done,
    output sdip_pkg::out_item_t                 result,
    input  logic                                cfg_we,
    input  logic [sdip_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sdip_pkg::MASK_W-1:0]         cfg_data
);

    // Configuration registers
    logic [sdip_pkg::MASK_W-1:0] bip_mask_reg;
    logic [sdip_pkg::MASK_W-1:0] lru_mask_reg;
    logic [sdip_pkg::THR_W-1:0]  throttle_reg;

    // Policy state
    logic [sdip_pkg::SELECTOR_BITS-1:0] sel_reg;
    logic [sdip_pkg::SELECTOR_BITS-1:0] sel_next;
    logic [sdip_pkg::SETS-1:0]          written_reg;

    // Stage register: the command whose RAM read is in flight
    logic                        stg_valid_reg;
    sdip_pkg::in_item_t          stg_item_reg;
    logic                        stg_written_reg;

    // Bypass of the write made at the previous edge (RAM read returns old data)
    logic                        fwd_valid_reg;
    logic [sdip_pkg::SET_W-1:0]  fwd_set_reg;
    sdip_pkg::order_t            fwd_order_reg;

    // Result register
    logic                        done_reg;
    sdip_pkg::out_item_t         result_reg;
    sdip_pkg::out_item_t         result_next;

    logic                        accept;
    logic [sdip_pkg::SET_W-1:0]  rd_set;
    logic [sdip_pkg::SET_W-1:0]  stg_set;
    logic                        stg_set_ok;
    logic [sdip_pkg::ORDER_W-1:0] ram_rdata;
    sdip_pkg::order_t            cur_order;
    logic                        stg_write;
    logic                        is_bip;
    logic                        is_lru;
    logic                        bimodal;
    sdip_pkg::rec_ctl_t          rec_ctl;
    sdip_pkg::rec_res_t          rec_res;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign rd_set = sdip_pkg::SET_W'(cmd.set_index);

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bip_mask_reg <= '0;
            lru_mask_reg <= '0;
            throttle_reg <= sdip_pkg::THROTTLE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sdip_pkg::CFG_BIP_MASK: bip_mask_reg <= cfg_data;
                sdip_pkg::CFG_LRU_MASK: lru_mask_reg <= cfg_data;
                sdip_pkg::CFG_THROTTLE: throttle_reg <= cfg_data[sdip_pkg::THR_W-1:0];
                default:                ;
            endcase
        end
    end

    // Recency RAM: read issued at accept, written from the stage
    sdip_ram #(
        .WIDTH (sdip_pkg::ORDER_W),
        .DEPTH (sdip_pkg::SETS)
    ) u_order_ram (
        .clk   (clk),
        .we    (stg_write),
        .waddr (stg_set),
        .wdata (rec_res.order),
        .raddr (rd_set),
        .rdata (ram_rdata)
    );

    // Stage: resolve the current order of the set
    assign stg_set    = sdip_pkg::SET_W'(stg_item_reg.set_index);
    assign stg_set_ok = 32'(stg_item_reg.set_index) < sdip_pkg::SETS;
    assign stg_write  = stg_valid_reg && stg_set_ok;

    always_comb
    begin
        if (fwd_valid_reg && (fwd_set_reg == stg_set))
        begin
            cur_order = fwd_order_reg;
        end
        else if (stg_written_reg)
        begin
            cur_order = sdip_pkg::order_t'(ram_rdata);
        end
        else
        begin
            cur_order = sdip_pkg::reset_order();
        end
    end

    // Selector update and insertion choice; a set in both masks counts as BIP
    always_comb
    begin
        is_bip   = bip_mask_reg[stg_set];
        is_lru   = !is_bip && lru_mask_reg[stg_set];
        sel_next = sel_reg;
        if (stg_valid_reg && stg_set_ok && (stg_item_reg.op == sdip_pkg::OP_MISS))
        begin
            if (is_bip && (sel_reg != '0))
            begin
                sel_next = sel_reg - 1'b1;
            end
            else if (is_lru && (sel_reg != sdip_pkg::SEL_MAX))
            begin
                sel_next = sel_reg + 1'b1;
            end
        end
        if (is_bip)
        begin
            bimodal = 1'b1;
        end
        else if (is_lru)
        begin
            bimodal = 1'b0;
        end
        else
        begin
            bimodal = sel_next > sdip_pkg::SEL_THRESHOLD;
        end
    end

    always_comb
    begin
        rec_ctl.miss         = stg_item_reg.op == sdip_pkg::OP_MISS;
        rec_ctl.way_ok       = 32'(stg_item_reg.hit_way) < sdip_pkg::WAYS;
        rec_ctl.way          = sdip_pkg::WAY_W'(stg_item_reg.hit_way);
        rec_ctl.fill_promote = !bimodal ||
            ({1'b0, stg_item_reg.rand_value} < throttle_reg);
    end

    sdip_recency u_recency (
        .order (cur_order),
        .ctl   (rec_ctl),
        .res   (rec_res)
    );

    // Assemble the result beat; out-of-range sets report only the selector
    always_comb
    begin
        result_next = '0;
        if (stg_set_ok)
        begin
            result_next.victim_way    = 3'(rec_res.victim);
            result_next.old_position  = 3'(rec_res.pos);
            result_next.moved_to_mru  = rec_res.moved;
            result_next.chose_bimodal = rec_ctl.miss && bimodal;
        end
        result_next.selector = 10'(sel_next);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            sel_reg       <= '0;
            written_reg   <= '0;
        end
        else
        begin
            stg_valid_reg <= accept;
            fwd_valid_reg <= stg_write;
            done_reg      <= stg_valid_reg;
            sel_reg       <= sel_next;
            if (stg_write)
            begin
                written_reg[stg_set] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_item_reg    <= cmd;
            stg_written_reg <= written_reg[rd_set];
        end
        if (stg_write)
        begin
            fwd_set_reg   <= stg_set;
            fwd_order_reg <= rec_res.order;
        end
        if (stg_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
